// ===== rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants for the Shanks limit extrapolator and its port checker.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN     = 32'h8000_0000;
  localparam logic [30:0] ERR_MAX     = 31'h7FFF_FFFF;
  // 1.0 in Q16.16, reported when no error estimate is available
  localparam logic [30:0] ERR_UNAVAIL = 31'd65536;
  localparam logic [15:0] TOL_RESET   = 16'd1;
  localparam int          QUOT_BITS   = 32;

endpackage

// ===== rtl/shanks_limit_extrapolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shanks_limit_extrapolator
// Iterated Shanks transformation over a table of signed Q16.16 terms, with
// one shared multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, term_value
//  out     | out_valid / out_ready| limit_estimate, error_estimate, term_count,
//          |                      | empty_flag, full_flag, saturated_flag
//  cfg     | cfg_valid / cfg_ready| cfg_data (tolerance)
//
//  A push onto n held terms runs floor(n/2) Shanks steps (3 reads, 3 multiplier
//  passes, sign fix, decision, a 32-bit bit-serial divide, saturation, writeback;
//  the divider is skipped when the guard, a zero denominator or a quotient
//  overflow decides the result), then the reporting states. A clear skips the
//  table reads in reporting; a refused push or a push onto fewer than two terms
//  runs no Shanks step. in_ready is high only while idle; a result still waiting
//  for transfer holds the sequencer in its last reporting state. rst is synchronous;
//  the term table has no reset, cfg_ready is always high.
module shanks_limit_extrapolator #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] term_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] limit_estimate,
  output logic        [30:0] error_estimate,
  output logic        [4:0]  term_count,
  output logic               empty_flag,
  output logic               full_flag,
  output logic               saturated_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [15:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int QW = sle_pkg::QUOT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_MUL_A, S_MUL_B, S_GUARD, S_ABS,
    S_DECIDE, S_DIV, S_SAT, S_WRITE, S_REP_A, S_REP_B, S_REP_C, S_REP_D
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        idx;
  logic [15:0]          tolerance;
  logic signed [31:0]   x1, x2, x3, top, res;
  logic [34:0]          den;
  logic [34:0]          den_mag;
  logic [63:0]          num;
  logic [63:0]          num_mag;
  logic signed [65:0]   prod;
  logic [34:0]          rem;
  logic [QW-1:0]        dq;
  logic [4:0]           div_cnt;
  logic                 neg_q;
  logic                 sat_seen;
  logic                 full_seen;

  logic [31:0]          mem [TABLE_DEPTH];
  logic [31:0]          rd_data;
  logic [AW-1:0]        ra, wa;
  logic [31:0]          wd;
  logic                 we;

  logic                 accept, table_full, guard, quot_ovf, hi_ok, out_free;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  logic [34:0]          rem_sh;
  logic [AW-1:0]        rep_idx, rep_idx_hi;
  logic [32:0]          diff, diff_mag;
  logic [30:0]          err_val;
  logic signed [31:0]   max12;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = (count >= CW'(TABLE_DEPTH));
  assign out_free   = !out_valid || out_ready;

  // best estimate sits at entry (count-1) mod 2
  assign rep_idx    = AW'({~count[0]});
  assign rep_idx_hi = AW'({~count[0], count[0]});
  assign hi_ok      = (count > CW'({~count[0], count[0]}));

  assign max12   = (x2 > x1) ? x2 : x1;
  assign rem_sh  = {rem[33:0], dq[QW-1]};
  assign guard   = !prod[65] && ($unsigned({15'd0, den_mag, 16'd0}) < $unsigned(prod));
  assign quot_ovf = ({3'd0, num_mag} >= {den_mag, 32'd0});

  assign diff     = {x1[31], x1} - {x2[31], x2};
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;
  assign err_val  = (|diff_mag[32:31]) ? sle_pkg::ERR_MAX : diff_mag[30:0];

  always_comb begin
    case (state)
      S_RD_A:  ra = idx - AW'(2);
      S_RD_B:  ra = idx - AW'(1);
      S_REP_B: ra = rep_idx_hi;
      default: ra = rep_idx;
    endcase
  end

  always_comb begin
    if (state == S_WRITE) begin
      we = 1'b1;
      wa = idx - AW'(2);
      wd = res;
    end else begin
      we = accept && !action && !table_full;
      wa = count[AW-1:0];
      wd = term_value;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_MUL_A: begin
        mul_a = {x1[31], x1};
        mul_b = {x3[31], x3};
      end
      S_MUL_B: begin
        mul_a = {x2[31], x2};
        mul_b = {x2[31], x2};
      end
      default: begin
        mul_a = {17'd0, tolerance};
        mul_b = {top[31], top};
      end
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      tolerance <= sle_pkg::TOL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tolerance <= cfg_data;
      end
      if (out_valid && out_ready && state != S_REP_D) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sat_seen  <= 1'b0;
            full_seen <= !action && table_full;
            x3        <= term_value;
            idx       <= count[AW-1:0];
            if (action) begin
              count <= '0;
              state <= S_REP_A;
            end else if (table_full) begin
              state <= S_REP_A;
            end else begin
              count <= count + CW'(1);
              state <= (count >= CW'(2)) ? S_RD_A : S_REP_A;
            end
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          x1    <= rd_data;
          state <= S_RD_C;
        end
        S_RD_C: begin
          x2    <= rd_data;
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          prod  <= mul_p;
          den   <= {{3{x1[31]}}, x1} - {{2{x2[31]}}, x2, 1'b0} + {{3{x3[31]}}, x3};
          top   <= (x3 > max12) ? x3 : max12;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          num   <= prod[63:0];
          prod  <= mul_p;
          state <= S_GUARD;
        end
        S_GUARD: begin
          num   <= num - prod[63:0];
          prod  <= mul_p;
          state <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= num[63] != den[34];
          num_mag <= num[63] ? (~num + 64'd1) : num;
          den_mag <= den[34] ? (~den + 35'd1) : den;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (guard || den_mag == '0) begin
            res   <= x2;
            state <= S_WRITE;
          end else if (quot_ovf) begin
            res      <= neg_q ? sle_pkg::S32_MIN : sle_pkg::S32_MAX;
            sat_seen <= 1'b1;
            state    <= S_WRITE;
          end else begin
            // upper half is already below the divisor
            rem     <= {3'd0, num_mag[63:32]};
            dq      <= num_mag[31:0];
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= den_mag) begin
            rem <= rem_sh - den_mag;
            dq  <= {dq[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dq  <= {dq[QW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(QW - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (!neg_q) begin
            if (dq[QW-1]) begin
              res      <= sle_pkg::S32_MAX;
              sat_seen <= 1'b1;
            end else begin
              res <= dq;
            end
          end else if (dq > sle_pkg::S32_MIN) begin
            res      <= sle_pkg::S32_MIN;
            sat_seen <= 1'b1;
          end else begin
            res <= ~dq + 32'd1;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          x3 <= res;
          if (idx > AW'(3)) begin
            idx   <= idx - AW'(2);
            state <= S_RD_A;
          end else begin
            state <= S_REP_A;
          end
        end
        S_REP_A: state <= (count == '0) ? S_REP_D : S_REP_B;
        S_REP_B: begin
          x1    <= rd_data;
          state <= S_REP_C;
        end
        S_REP_C: begin
          x2    <= rd_data;
          state <= S_REP_D;
        end
        S_REP_D: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            term_count     <= 5'(count);
            empty_flag     <= (count == '0);
            full_flag      <= full_seen;
            saturated_flag <= sat_seen;
            if (count == '0) begin
              limit_estimate <= '0;
              error_estimate <= sle_pkg::ERR_UNAVAIL;
            end else begin
              limit_estimate <= x1;
              error_estimate <= hi_ok ? err_val : sle_pkg::ERR_UNAVAIL;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the Shanks limit extrapolator, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] limit_estimate,
  input logic        [30:0] error_estimate,
  input logic        [4:0]  term_count,
  input logic               empty_flag,
  input logic               full_flag,
  input logic               saturated_flag
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && out_valid && !out_ready |=>
      out_valid && $stable(limit_estimate) && $stable(error_estimate))
    else $error("result changed while stalled");

  // one item at a time: busy after every input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_flag |->
      limit_estimate == 32'sd0 && error_estimate == sle_pkg::ERR_UNAVAIL &&
      term_count == 5'd0)
    else $error("empty result not reported as empty");

  // a refused push runs no Shanks step and leaves a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_flag |-> !empty_flag && !saturated_flag)
    else $error("inconsistent flags on refused push");

endmodule

bind shanks_limit_extrapolator sle_checker u_sle_checker (.*);

// ===== tb/sle_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_result_checker
// Watches the input, result and tolerance channels of the Shanks limit
// extrapolator, keeps its own copy of the term table, predicts each result
// and compares it field by field with what comes out of the block.
// ----------------------------------------------------------------------------
module sle_result_checker #(
  parameter int   TABLE_DEPTH  = 16,
  parameter logic CLEAR_ACTION = 1'b1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] term_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] limit_estimate,
  input  logic        [30:0] error_estimate,
  input  logic        [4:0]  term_count,
  input  logic               empty_flag,
  input  logic               full_flag,
  input  logic               saturated_flag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic        [15:0] cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [31:0] best;
    logic [30:0] err;
    logic [4:0]  count;
    logic        empty;
    logic        full;
    logic        sat;
  } estimate_t;

  logic signed [31:0] terms [TABLE_DEPTH];
  int unsigned        held;
  logic [15:0]        tolerance;
  estimate_t          estimates_due [$];
  int                 mismatch_total;
  int                 results_seen;

  assign mismatches = mismatch_total;

  task automatic log_failure(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    mismatch_total++;
  endtask

  // One Shanks step on three neighbouring terms, with the relative guard
  function automatic logic [31:0] shanks_combine(input longint x1, input longint x2,
                                                 input longint x3, input logic [15:0] tol,
                                                 output bit sat);
    longint            den, top, lhs, rhs, num, tol64, neg_q;
    longint unsigned   dmag, nmag, q;
    bit                neg;
    sat   = 1'b0;
    tol64 = tol;
    den   = x1 - 2 * x2 + x3;
    top   = x1;
    if (x2 > top) top = x2;
    if (x3 > top) top = x3;
    dmag = (den < 0) ? -den : den;
    lhs  = dmag * 65536;
    // signed maximum: a negative top can never trip the guard
    rhs  = tol64 * top;
    if (lhs < rhs || den == 0)
      return x2[31:0];
    num  = x1 * x3 - x2 * x2;
    neg  = (num < 0) != (den < 0);
    nmag = (num < 0) ? -num : num;
    q    = nmag / dmag;
    if (!neg) begin
      if (q > 64'h0000_0000_7FFF_FFFF) begin
        sat = 1'b1;
        return sle_pkg::S32_MAX;
      end
      return q[31:0];
    end
    if (q > 64'h0000_0000_8000_0000) begin
      sat = 1'b1;
      return sle_pkg::S32_MIN;
    end
    neg_q = -longint'(q);
    return neg_q[31:0];
  endfunction

  task automatic predict_estimate(input logic act, input logic [31:0] word);
    int unsigned n, k, sel;
    bit          sat_one, sat_any, refused;
    longint      diff;
    estimate_t   want;
    sat_any = 1'b0;
    refused = 1'b0;
    if (act == CLEAR_ACTION) begin
      held = 0;
    end else if (held >= TABLE_DEPTH) begin
      refused = 1'b1;
    end else begin
      n        = held;
      terms[n] = word;
      held     = n + 1;
      k        = n;
      while (k >= 2) begin
        terms[k-2] = shanks_combine(terms[k-2], terms[k-1], terms[k], tolerance, sat_one);
        sat_any   |= sat_one;
        k         -= 2;
      end
    end
    want.best = '0;
    want.err  = sle_pkg::ERR_UNAVAIL;
    if (held > 0) begin
      sel       = (held - 1) % 2;
      want.best = terms[sel];
      if (sel + 1 < held) begin
        diff = longint'(terms[sel]) - longint'(terms[sel+1]);
        if (diff < 0) diff = -diff;
        want.err = (diff > 64'sh7FFF_FFFF) ? sle_pkg::ERR_MAX : diff[30:0];
      end
    end
    want.count = held[4:0];
    want.empty = (held == 0);
    want.full  = refused;
    want.sat   = sat_any;
    estimates_due.insert(estimates_due.size(), want);
  endtask

  task automatic check_result();
    estimate_t want;
    if (estimates_due.size() == 0) begin
      log_failure($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = estimates_due.pop_front();
      if (limit_estimate !== want.best)
        log_failure($sformatf("result %0d limit_estimate %h, expected %h",
                              results_seen, limit_estimate, want.best));
      if (error_estimate !== want.err)
        log_failure($sformatf("result %0d error_estimate %h, expected %h",
                              results_seen, error_estimate, want.err));
      if (term_count !== want.count)
        log_failure($sformatf("result %0d term_count %0d, expected %0d",
                              results_seen, term_count, want.count));
      if (empty_flag !== want.empty)
        log_failure($sformatf("result %0d empty_flag %b, expected %b",
                              results_seen, empty_flag, want.empty));
      if (full_flag !== want.full)
        log_failure($sformatf("result %0d full_flag %b, expected %b",
                              results_seen, full_flag, want.full));
      if (saturated_flag !== want.sat)
        log_failure($sformatf("result %0d saturated_flag %b, expected %b",
                              results_seen, saturated_flag, want.sat));
    end
    results_seen++;
  endtask

  initial begin
    mismatch_total = 0;
    results_seen   = 0;
    held           = 0;
    tolerance      = sle_pkg::TOL_RESET;
    outstanding    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      held      = 0;
      tolerance = sle_pkg::TOL_RESET;
      estimates_due.delete();
    end else begin
      // results first, so a transfer can never match an item taken at the same edge
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (in_valid && in_ready) predict_estimate(action, term_value);
    end
    outstanding <= estimates_due.size();
  end

endmodule

// ===== tb/tb_shanks_limit_extrapolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shanks_limit_extrapolator
// Drives sequences of Q16.16 terms and clears into the extrapolator under
// several tolerance settings and back-pressure patterns; the result checker
// beside the block predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_shanks_limit_extrapolator;

  localparam int   TABLE_DEPTH = 16;
  localparam int   SEG_ITEMS   = 290;
  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef enum logic [1:0] {SEQ_GEOMETRIC, SEQ_SMALL, SEQ_EXTREME, SEQ_NOISE} seq_kind_t;

  logic               clk;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               action     = 1'b0;
  logic signed [31:0] term_value = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [31:0] limit_estimate;
  logic        [30:0] error_estimate;
  logic        [4:0]  term_count;
  logic               empty_flag;
  logic               full_flag;
  logic               saturated_flag;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic        [15:0] cfg_data   = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fill          = 0;

  shanks_limit_extrapolator #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
    .clk, .rst, .in_valid, .in_ready, .action, .term_value,
    .out_valid, .out_ready, .limit_estimate, .error_estimate, .term_count,
    .empty_flag, .full_flag, .saturated_flag, .cfg_valid, .cfg_ready, .cfg_data
  );

  sle_result_checker #(.TABLE_DEPTH(TABLE_DEPTH), .CLEAR_ACTION(ACT_CLEAR)) i_checker (
    .clk, .rst, .in_valid, .in_ready, .action, .term_value,
    .out_valid, .out_ready, .limit_estimate, .error_estimate, .term_count,
    .empty_flag, .full_flag, .saturated_flag, .cfg_valid, .cfg_ready, .cfg_data,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic act, input logic [31:0] word);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    term_value <= word;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_CLEAR) fill = 0;
    else if (fill < TABLE_DEPTH) fill++;
  endtask

  // every item yields a result, so an empty checker queue means the block is idle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_write(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #20_000_000;
    $display("tb_shanks_limit_extrapolator: errors");
    $finish;
  end

  initial begin
    logic [31:0] word;
    logic [15:0] tol_pick;
    int          kind_pick;
    longint      g_limit;
    longint      g_delta;
    longint      g_ratio;
    seq_kind_t   kind;

    kind    = SEQ_GEOMETRIC;
    g_limit = 0;
    g_delta = 64'sd1 << 20;
    g_ratio = 32768;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 10;
    recv_idle_pct = 82;

    // no guard at all, so the saturating quotients get through
    cfg_write(16'd0);
    send_item(ACT_CLEAR, 32'hDEAD_BEEF);
    // negative saturation, then an error difference too wide for 31 bits
    send_item(ACT_PUSH, 32'h4000_0001);
    send_item(ACT_PUSH, 32'h0000_0001);
    send_item(ACT_PUSH, 32'hC000_0002);
    send_item(ACT_CLEAR, 32'h0);
    // positive saturation
    send_item(ACT_PUSH, 32'h0000_0000);
    send_item(ACT_PUSH, 32'h4000_0000);
    send_item(ACT_PUSH, sle_pkg::S32_MAX);
    wait_results_drained();

    cfg_write(16'hFFFF);
    send_item(ACT_CLEAR, 32'h0);
    // constant negative run: zero denominator that the guard lets through
    repeat (3) send_item(ACT_PUSH, 32'hFFFF_FFFD);
    for (int k = 0; k < TABLE_DEPTH - 3; k++)
      send_item(ACT_PUSH, k[0] ? sle_pkg::S32_MIN : sle_pkg::S32_MAX - k);
    // table full: refused
    send_item(ACT_PUSH, 32'h1234_5678);

    for (int seg = 0; seg < 6; seg++) begin
      wait_results_drained();
      case (seg)
        0:       tol_pick = 16'd0;
        1:       tol_pick = 16'hFFFF;
        2:       tol_pick = 16'd1;
        4:       tol_pick = 16'h8000;
        default: tol_pick = 16'($urandom_range(65535));
      endcase
      cfg_write(tol_pick);
      case (seg / 2)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      repeat (SEG_ITEMS) begin
        if ((fill >= TABLE_DEPTH && $urandom_range(99) < 30) || $urandom_range(99) < 4) begin
          kind_pick = $urandom_range(19);
          if (kind_pick < 11)      kind = SEQ_GEOMETRIC;
          else if (kind_pick < 14) kind = SEQ_SMALL;
          else if (kind_pick < 17) kind = SEQ_EXTREME;
          else                     kind = SEQ_NOISE;
          // convergent run: limit plus a geometrically shrinking offset
          g_limit = int'($urandom) >>> 6;
          g_delta = int'($urandom) >>> $urandom_range(1, 12);
          g_ratio = longint'($urandom_range(124518)) - 62259;
          send_item(ACT_CLEAR, $urandom);
        end else begin
          case (kind)
            SEQ_GEOMETRIC: begin
              word    = 32'(g_limit + g_delta);
              g_delta = (g_delta * g_ratio) >>> 16;
            end
            SEQ_SMALL: word = 32'($urandom_range(262143)) - 32'd131072;
            SEQ_EXTREME: begin
              case ($urandom_range(7))
                0:       word = sle_pkg::S32_MAX;
                1:       word = sle_pkg::S32_MIN;
                2:       word = 32'h0000_0000;
                3:       word = 32'hFFFF_FFFF;
                4:       word = 32'h0000_0001;
                5:       word = 32'h4000_0000;
                6:       word = 32'hC000_0000;
                default: word = 32'h0001_0000;
              endcase
            end
            default: word = $urandom;
          endcase
          send_item(ACT_PUSH, word);
        end
      end
    end

    wait_results_drained();
    // room for any stray result after the last expected one
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_shanks_limit_extrapolator: clean");
    else
      $display("tb_shanks_limit_extrapolator: errors");
    $finish;
  end

endmodule
